@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bfr_pkg.sv @@
// ----------------------------------------------------------------------------
// bfr_pkg
// Types, codes and reset values shared by the byte frame receiver.
// ----------------------------------------------------------------------------
package bfr_pkg;

    // Default time stamp width
    localparam int TIME_WIDTH_DEF = 32;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_BYTE  = 3'd0;
    localparam logic [2:0] CFG_END_BYTE    = 3'd1;
    localparam logic [2:0] CFG_MAX_PAYLOAD = 3'd2;
    localparam logic [2:0] CFG_GAP_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_FRAME_LIMIT = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_START_BYTE  = 8'd170;
    localparam logic [7:0]  RST_END_BYTE    = 8'd85;
    localparam logic [7:0]  RST_MAX_PAYLOAD = 8'd64;
    localparam logic [31:0] RST_GAP_LIMIT   = 32'd10;
    localparam logic [31:0] RST_FRAME_LIMIT = 32'd100;

    // Receiver phase, also reported as status
    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_START2 = 4'd1,
        PH_LEN    = 4'd2,
        PH_DATA   = 4'd3,
        PH_CHECK  = 4'd4,
        PH_END1   = 4'd5,
        PH_END2   = 4'd6,
        PH_DONE   = 4'd7,
        PH_ERROR  = 4'd8
    } t_phase;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_GAP    = 3'd1,
        ERR_FRAME  = 3'd2,
        ERR_START  = 3'd3,
        ERR_LENGTH = 3'd4,
        ERR_CHECK  = 3'd5,
        ERR_END    = 3'd6
    } t_err;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [7:0]  max_payload;
        logic [31:0] gap_limit;
        logic [31:0] frame_limit;
    } t_cfg;

    // One result item
    typedef struct packed {
        t_phase      status;
        t_err        error_code;
        logic        payload_valid;
        logic [7:0]  payload_index;
        logic        check_valid;
        logic [7:0]  byte_out;
        logic [7:0]  frame_length;
    } t_result;

endpackage

@@ sv/bfr_fsm.sv @@
// ----------------------------------------------------------------------------
// bfr_fsm
// Frame state machine: timeout checks, phase sequencing, payload count and
// running XOR. Result for the presented item is combinational; state moves
// on i_step.
// ----------------------------------------------------------------------------
module bfr_fsm #(
    parameter int TIME_WIDTH = bfr_pkg::TIME_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_action,
    input  logic [7:0]        i_data_byte,
    input  logic [31:0]       i_now_time,
    input  bfr_pkg::t_cfg     i_cfg,
    output bfr_pkg::t_result  o_result
);

    // Compare width covers both the stamp difference and the 32-bit limits
    localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    bfr_pkg::t_phase        r_phase, n_phase;
    bfr_pkg::t_err          r_error, n_error;
    logic [TIME_WIDTH-1:0]  r_last_stamp, n_last_stamp;
    logic [TIME_WIDTH-1:0]  r_start_stamp, n_start_stamp;
    logic [7:0]             r_expected, n_expected;
    logic [7:0]             r_received, n_received;
    logic [7:0]             r_xor, n_xor;

    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  gap_diff;
    logic [TIME_WIDTH-1:0]  frame_diff;
    logic                   gap_over;
    logic                   frame_over;

    // Time stamp cut or widened to the stamp width; wrap-around differences
    assign now_t      = TIME_WIDTH'(i_now_time);
    assign gap_diff   = now_t - r_last_stamp;
    assign frame_diff = now_t - r_start_stamp;
    assign gap_over   = CMP_W'(gap_diff) > CMP_W'(i_cfg.gap_limit);
    assign frame_over = CMP_W'(frame_diff) > CMP_W'(i_cfg.frame_limit);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= bfr_pkg::PH_HUNT;
            r_error       <= bfr_pkg::ERR_NONE;
            r_last_stamp  <= '0;
            r_start_stamp <= '0;
            r_expected    <= '0;
            r_received    <= '0;
            r_xor         <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_error       <= n_error;
            r_last_stamp  <= n_last_stamp;
            r_start_stamp <= n_start_stamp;
            r_expected    <= n_expected;
            r_received    <= n_received;
            r_xor         <= n_xor;
        end
    end

    // Next state and result
    always_comb begin
        n_phase       = r_phase;
        n_error       = r_error;
        n_last_stamp  = r_last_stamp;
        n_start_stamp = r_start_stamp;
        n_expected    = r_expected;
        n_received    = r_received;
        n_xor         = r_xor;

        o_result               = '0;
        o_result.status        = bfr_pkg::PH_HUNT;
        o_result.error_code    = bfr_pkg::ERR_NONE;

        if (i_action) begin
            // restart: all state back to hunting
            n_phase       = bfr_pkg::PH_HUNT;
            n_error       = bfr_pkg::ERR_NONE;
            n_last_stamp  = '0;
            n_start_stamp = '0;
            n_expected    = '0;
            n_received    = '0;
            n_xor         = '0;
        end else if (r_phase != bfr_pkg::PH_HUNT && gap_over) begin
            n_phase = bfr_pkg::PH_ERROR;
            n_error = bfr_pkg::ERR_GAP;
        end else if (r_phase != bfr_pkg::PH_HUNT && frame_over) begin
            n_phase = bfr_pkg::PH_ERROR;
            n_error = bfr_pkg::ERR_FRAME;
        end else begin
            n_last_stamp = now_t;
            case (r_phase)
                bfr_pkg::PH_HUNT: begin
                    if (i_data_byte == i_cfg.start_byte) begin
                        n_phase       = bfr_pkg::PH_START2;
                        n_start_stamp = now_t;
                    end
                end
                bfr_pkg::PH_START2: begin
                    if (i_data_byte == i_cfg.start_byte) begin
                        n_phase = bfr_pkg::PH_LEN;
                    end else begin
                        n_phase = bfr_pkg::PH_ERROR;
                        n_error = bfr_pkg::ERR_START;
                    end
                end
                bfr_pkg::PH_LEN: begin
                    if (i_data_byte == 8'd0 || i_data_byte > i_cfg.max_payload) begin
                        n_phase = bfr_pkg::PH_ERROR;
                        n_error = bfr_pkg::ERR_LENGTH;
                    end else begin
                        n_expected = i_data_byte;
                        n_received = '0;
                        n_xor      = '0;
                        n_phase    = bfr_pkg::PH_DATA;
                    end
                end
                bfr_pkg::PH_DATA: begin
                    o_result.payload_valid = 1'b1;
                    o_result.payload_index = r_received;
                    o_result.byte_out      = i_data_byte;
                    n_received             = r_received + 8'd1;
                    n_xor                  = r_xor ^ i_data_byte;
                    if (n_received >= r_expected) begin
                        n_phase = bfr_pkg::PH_CHECK;
                    end
                end
                bfr_pkg::PH_CHECK: begin
                    // byte is echoed even on mismatch
                    o_result.check_valid = 1'b1;
                    o_result.byte_out    = i_data_byte;
                    if (i_data_byte != r_xor) begin
                        n_phase = bfr_pkg::PH_ERROR;
                        n_error = bfr_pkg::ERR_CHECK;
                    end else begin
                        n_error = bfr_pkg::ERR_NONE;
                        n_phase = bfr_pkg::PH_END1;
                    end
                end
                bfr_pkg::PH_END1: begin
                    if (i_data_byte == i_cfg.end_byte) begin
                        n_phase = bfr_pkg::PH_END2;
                    end else begin
                        n_phase = bfr_pkg::PH_ERROR;
                        n_error = bfr_pkg::ERR_END;
                    end
                end
                bfr_pkg::PH_END2: begin
                    if (i_data_byte == i_cfg.end_byte) begin
                        n_error = bfr_pkg::ERR_NONE;
                        n_phase = bfr_pkg::PH_DONE;
                    end else begin
                        n_phase = bfr_pkg::PH_ERROR;
                        n_error = bfr_pkg::ERR_END;
                    end
                end
                default: begin
                    // done and error hold here; only the stamp moves
                end
            endcase
        end

        o_result.status       = n_phase;
        o_result.error_code   = n_error;
        o_result.frame_length = n_expected;
    end

endmodule

@@ sv/byte_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// byte_frame_receiver_unit
// Framed byte stream receiver with timeouts and XOR check.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (i_in_valid / o_in_ready) carries one item per byte: an
//   action bit (0 process byte, 1 restart), the byte and its time stamp.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   item per input item: phase, error code, payload/check echo and length.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the start and
//   end byte values, maximum length and the two time limits; write only
//   while no item is in flight. It is always ready.
// Pipeline and throughput:
//   An item is held in the input register, then the frame state machine
//   updates and its result is captured in the output register. One item
//   per cycle sustained while the output is not stalled; the state update
//   of one item feeds the next in the cycle after, through the state
//   machine registers.
// Reset: synchronous, clears both pipeline stages, the frame state and
//   reloads the configuration defaults.
// Stall: while a result waits and i_out_ready is low the output register
//   holds, the input register fills, and o_in_ready drops until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_frame_receiver_unit #(
    parameter int TIME_WIDTH = bfr_pkg::TIME_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // input items
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic         i_action,
    input  logic [7:0]   i_data_byte,
    input  logic [31:0]  i_now_time,
    // result items
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [3:0]   o_status,
    output logic [2:0]   o_error_code,
    output logic         o_payload_valid,
    output logic [7:0]   o_payload_index,
    output logic         o_check_valid,
    output logic [7:0]   o_byte_out,
    output logic [7:0]   o_frame_length
);

    bfr_pkg::t_cfg     r_cfg;
    logic              r_s1_valid;
    logic              r_s1_action;
    logic [7:0]        r_s1_byte;
    logic [31:0]       r_s1_time;
    logic              r_out_valid;
    bfr_pkg::t_result  r_out;
    bfr_pkg::t_result  fsm_result;
    logic              s1_adv;
    logic              in_acc;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= bfr_pkg::RST_START_BYTE;
            r_cfg.end_byte    <= bfr_pkg::RST_END_BYTE;
            r_cfg.max_payload <= bfr_pkg::RST_MAX_PAYLOAD;
            r_cfg.gap_limit   <= bfr_pkg::RST_GAP_LIMIT;
            r_cfg.frame_limit <= bfr_pkg::RST_FRAME_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bfr_pkg::CFG_START_BYTE:  r_cfg.start_byte  <= i_cfg_data[7:0];
                bfr_pkg::CFG_END_BYTE:    r_cfg.end_byte    <= i_cfg_data[7:0];
                bfr_pkg::CFG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data[7:0];
                bfr_pkg::CFG_GAP_LIMIT:   r_cfg.gap_limit   <= i_cfg_data;
                bfr_pkg::CFG_FRAME_LIMIT: r_cfg.frame_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_action <= i_action;
            r_s1_byte   <= i_data_byte;
            r_s1_time   <= i_now_time;
        end
    end

    // Frame state machine
    bfr_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_adv),
        .i_action    (r_s1_action),
        .i_data_byte (r_s1_byte),
        .i_now_time  (r_s1_time),
        .i_cfg       (r_cfg),
        .o_result    (fsm_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= fsm_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_error_code    = r_out.error_code;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_index = r_out.payload_index;
    assign o_check_valid   = r_out.check_valid;
    assign o_byte_out      = r_out.byte_out;
    assign o_frame_length  = r_out.frame_length;

    // Checks
    `ASSERT_NEXT(a_restart_hunts, s1_adv && r_s1_action, o_out_valid && o_status == bfr_pkg::PH_HUNT && o_error_code == bfr_pkg::ERR_NONE, "restart item did not return to hunting")
    `ASSERT_IMPL(a_err_matches_phase, o_out_valid, (o_status == bfr_pkg::PH_ERROR) == (o_error_code != bfr_pkg::ERR_NONE), "error code disagrees with status")
    `ASSERT_IMPL(a_one_echo, o_out_valid, !(o_payload_valid && o_check_valid), "payload and check echo both set")
    `ASSERT_NEXT(a_s1_held, r_s1_valid && !s1_adv, r_s1_valid, "stalled item dropped from input register")

endmodule
